// File: design/nnp_pkg.sv
// Shared types, character codes and decode helpers for the note name parser.
// No dependencies; the other design files but nnp_checker refer to it by scoped names.
package nnp_pkg;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_ADDR_W-1:0] CFG_HEX_DEFAULT = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIDDLE_C    = 1'd1;

    localparam logic signed [4:0] MIDDLE_C_RESET = 5'sd3;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_FLAT   = 8'h62;
    localparam logic [7:0] CH_LOW_D  = 8'h64;
    localparam logic [7:0] CH_LOW_X  = 8'h78;

    // Position of a number parse relative to its optional prefix
    typedef enum logic [1:0] {
        NUM_PREFIX = 2'd0,
        NUM_ZERO   = 2'd1,
        NUM_DIGITS = 2'd2
    } num_pos_t;

    typedef struct packed {
        num_pos_t pos;
        logic     hex;
        logic     ok;
    } num_ctl_t;

    typedef enum logic [2:0] {
        NP_LETTER     = 3'd0,
        NP_NOTE       = 3'd1,
        NP_ACCID      = 3'd2,
        NP_MINUS      = 3'd3,
        NP_OCT_ZERO   = 3'd4,
        NP_OCT_DIGITS = 3'd5
    } name_phase_t;

    typedef struct packed {
        logic       valid;
        logic [6:0] note;
    } name_res_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } digit_t;

    typedef struct packed {
        logic              valid;
        logic signed [4:0] semi;
    } letter_t;

    function automatic digit_t digit_of(input logic [7:0] c);
        digit_t r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.valid = 1'b1;
            r.value = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r.valid = 1'b1;
            r.value = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r.valid = 1'b1;
            r.value = 4'(c - 8'h57);
        end
        return r;
    endfunction

    // Note letter to semitone within the octave; H counts as B
    function automatic letter_t letter_of(input logic [7:0] c);
        letter_t r;
        r = '{valid: 1'b1, semi: 5'sd0};
        unique case (c)
            8'h43, 8'h63: r.semi = 5'sd0;
            8'h44, 8'h64: r.semi = 5'sd2;
            8'h45, 8'h65: r.semi = 5'sd4;
            8'h46, 8'h66: r.semi = 5'sd5;
            8'h47, 8'h67: r.semi = 5'sd7;
            8'h41, 8'h61: r.semi = 5'sd9;
            8'h42, 8'h62, 8'h48, 8'h68: r.semi = 5'sd11;
            default: r.valid = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// File: design/nnp_num_acc.sv
// Next-state logic of one number parse: prefix handling plus saturating digit accumulate.
// Depends on nnp_pkg.
module nnp_num_acc #(
    parameter int MAX_DIGITS = 255,
    parameter int CAP        = 255,
    localparam int VW = $clog2(CAP + 1),
    localparam int CW = $clog2(MAX_DIGITS + 1)
) (
    input  logic [7:0]       char_i,
    input  logic             hex_default_i,
    input  nnp_pkg::num_ctl_t ctl_i,
    input  logic [VW-1:0]    value_i,
    input  logic [CW-1:0]    count_i,
    output nnp_pkg::num_ctl_t ctl_o,
    output logic [VW-1:0]    value_o,
    output logic [CW-1:0]    count_o
);

    function automatic void take_digit(input logic [7:0] c, input logic hx,
                                       inout logic [VW-1:0] v, inout logic ok,
                                       inout logic [CW-1:0] cnt);
        nnp_pkg::digit_t d;
        logic [VW+3:0]   acc;
        d   = nnp_pkg::digit_of(c);
        acc = '0;
        if (ok && (cnt < CW'(MAX_DIGITS))) begin
            if (!d.valid || (!hx && d.value > 4'd9)) begin
                ok = 1'b0;
            end else begin
                acc = hx ? {v, 4'b0000} : ({1'b0, v, 3'b000} + {3'b000, v, 1'b0});
                acc = acc + (VW+4)'(d.value);
                v   = (acc > (VW+4)'(CAP)) ? VW'(CAP) : acc[VW-1:0];
                cnt = cnt + 1'b1;
            end
        end
    endfunction

    always_comb begin
        logic [VW-1:0] v;
        logic [CW-1:0] cnt;
        logic          ok;
        logic          hx;
        v     = value_i;
        cnt   = count_i;
        ok    = ctl_i.ok;
        hx    = ctl_i.hex;
        ctl_o = ctl_i;
        unique case (ctl_i.pos)
            nnp_pkg::NUM_PREFIX: begin
                ctl_o.pos = nnp_pkg::NUM_DIGITS;
                if (char_i == nnp_pkg::CH_DOLLAR) begin
                    hx = 1'b1;
                end else if (char_i == nnp_pkg::CH_BANG) begin
                    hx = 1'b0;
                end else if (char_i == nnp_pkg::CH_ZERO) begin
                    ctl_o.pos = nnp_pkg::NUM_ZERO;
                end else begin
                    hx = hex_default_i;
                    take_digit(char_i, hx, v, ok, cnt);
                end
            end
            nnp_pkg::NUM_ZERO: begin
                ctl_o.pos = nnp_pkg::NUM_DIGITS;
                if (char_i == nnp_pkg::CH_LOW_X) begin
                    hx = 1'b1;
                end else if (char_i == nnp_pkg::CH_LOW_D) begin
                    hx = 1'b0;
                end else begin
                    // leading zero was a digit after all
                    hx = hex_default_i;
                    take_digit(nnp_pkg::CH_ZERO, hx, v, ok, cnt);
                    take_digit(char_i, hx, v, ok, cnt);
                end
            end
            default: begin
                take_digit(char_i, hx, v, ok, cnt);
            end
        endcase
        ctl_o.hex = hx;
        ctl_o.ok  = ok;
        value_o   = v;
        count_o   = cnt;
    end

endmodule

// File: design/nnp_name_path.sv
// Note-name parse: letter, accidental, sign and octave number, plus the note arithmetic.
// Depends on nnp_pkg and nnp_num_acc.
module nnp_name_path #(
    parameter int MAX_DIGITS = 255,
    localparam int CW = $clog2(MAX_DIGITS + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_i,
    input  logic               clear_i,
    input  logic [7:0]         char_i,
    input  logic               hex_default_i,
    input  logic signed [4:0]  middle_c_i,
    output nnp_pkg::name_res_t res_o
);

    localparam int OCT_CAP = 31;
    localparam int OW      = $clog2(OCT_CAP + 1);

    nnp_pkg::name_phase_t phase_reg, phase_next;
    logic                 ok_reg, ok_next;
    logic signed [4:0]    semi_reg, semi_next;
    logic                 neg_reg, neg_next;
    logic                 oct_hex_reg, oct_hex_next;
    logic [OW-1:0]        oct_value_reg, oct_value_next;
    logic [CW-1:0]        oct_count_reg, oct_count_next;

    nnp_pkg::num_ctl_t    acc_ctl_in, acc_ctl_out;
    logic [OW-1:0]        acc_value;
    logic [CW-1:0]        acc_count;
    nnp_pkg::letter_t     letter;

    logic signed [7:0]    oct_s;
    logic signed [7:0]    base_s;
    logic signed [11:0]   base_w;
    logic signed [11:0]   note_s;

    always_comb begin
        unique case (phase_reg)
            nnp_pkg::NP_OCT_ZERO:   acc_ctl_in.pos = nnp_pkg::NUM_ZERO;
            nnp_pkg::NP_OCT_DIGITS: acc_ctl_in.pos = nnp_pkg::NUM_DIGITS;
            default:                acc_ctl_in.pos = nnp_pkg::NUM_PREFIX;
        endcase
        acc_ctl_in.hex = oct_hex_reg;
        acc_ctl_in.ok  = ok_reg;
    end

    nnp_num_acc #(
        .MAX_DIGITS (MAX_DIGITS),
        .CAP        (OCT_CAP)
    ) u_oct_acc (
        .char_i        (char_i),
        .hex_default_i (hex_default_i),
        .ctl_i         (acc_ctl_in),
        .value_i       (oct_value_reg),
        .count_i       (oct_count_reg),
        .ctl_o         (acc_ctl_out),
        .value_o       (acc_value),
        .count_o       (acc_count)
    );

    assign letter = nnp_pkg::letter_of(char_i);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= nnp_pkg::NP_LETTER;
            ok_reg        <= 1'b1;
            semi_reg      <= '0;
            neg_reg       <= 1'b0;
            oct_hex_reg   <= 1'b0;
            oct_value_reg <= '0;
            oct_count_reg <= '0;
        end else begin
            phase_reg     <= phase_next;
            ok_reg        <= ok_next;
            semi_reg      <= semi_next;
            neg_reg       <= neg_next;
            oct_hex_reg   <= oct_hex_next;
            oct_value_reg <= oct_value_next;
            oct_count_reg <= oct_count_next;
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        ok_next        = ok_reg;
        semi_next      = semi_reg;
        neg_next       = neg_reg;
        oct_hex_next   = oct_hex_reg;
        oct_value_next = oct_value_reg;
        oct_count_next = oct_count_reg;
        if (clear_i) begin
            phase_next     = nnp_pkg::NP_LETTER;
            ok_next        = 1'b1;
            semi_next      = '0;
            neg_next       = 1'b0;
            oct_hex_next   = 1'b0;
            oct_value_next = '0;
            oct_count_next = '0;
        end else if (step_i && ok_reg) begin
            priority if (phase_reg == nnp_pkg::NP_LETTER) begin
                if (letter.valid) begin
                    semi_next  = letter.semi;
                    phase_next = nnp_pkg::NP_NOTE;
                end else begin
                    ok_next = 1'b0;
                end
            end else if (phase_reg == nnp_pkg::NP_NOTE
                         && (char_i == nnp_pkg::CH_FLAT || char_i == nnp_pkg::CH_HASH)) begin
                semi_next  = (char_i == nnp_pkg::CH_HASH) ? semi_reg + 5'sd1
                                                          : semi_reg - 5'sd1;
                phase_next = nnp_pkg::NP_ACCID;
            end else if ((phase_reg == nnp_pkg::NP_NOTE || phase_reg == nnp_pkg::NP_ACCID)
                         && char_i == nnp_pkg::CH_MINUS) begin
                neg_next   = 1'b1;
                phase_next = nnp_pkg::NP_MINUS;
            end else begin
                ok_next        = acc_ctl_out.ok;
                oct_hex_next   = acc_ctl_out.hex;
                oct_value_next = acc_value;
                oct_count_next = acc_count;
                phase_next     = (acc_ctl_out.pos == nnp_pkg::NUM_ZERO)
                                 ? nnp_pkg::NP_OCT_ZERO : nnp_pkg::NP_OCT_DIGITS;
            end
        end
    end

    // note = (octave + 5 - middle C) * 12 + semitone
    always_comb begin
        oct_s  = neg_reg ? -$signed({3'b000, oct_value_reg}) : $signed({3'b000, oct_value_reg});
        base_s = oct_s + 8'sd5 - 8'(middle_c_i);
        base_w = 12'(base_s);
        note_s = (base_w <<< 3) + (base_w <<< 2) + 12'(semi_reg);
        res_o.valid = ok_reg && (phase_reg != nnp_pkg::NP_LETTER)
                      && !note_s[11] && (note_s[10:7] == 4'd0);
        res_o.note  = note_s[6:0];
    end

endmodule

// File: design/note_name_parser_top.sv
// Note name parser, top level: handshakes, config registers, numeric parse, result register.
// Depends on nnp_pkg, nnp_num_acc and nnp_name_path.
//
// Usage:
//   The input channel (s_valid / s_ready / s_char_code) carries a token one
//   character per beat. A zero character terminates the token and produces
//   exactly one beat on the result channel (m_valid / m_ready) carrying
//   m_note_number, m_note_valid and m_from_name. Other characters produce no
//   result beat. The token is parsed both as a number (with $, 0x, ! or 0d
//   prefixes, else the base set by hex_default) and as a note name; a number
//   in 0..127 wins over the name.
//   Path: a terminator passes the input register, then the output register.
//   Throughput: one character per cycle unless a terminator stalls, set by
//   the single input register feeding the token state update; the next beat
//   is accepted while a result waits in the output register.
//   Stall: when the output register is full and m_ready is low, a terminator
//   holds in the input register and s_ready drops; non-terminators keep
//   flowing into the token state.
//   Reset (aresetn low, synchronous): both channels empty, token state cleared,
//   hex_default = 0, middle_c_octave = 3.
//   Configuration: cfg_wr_en writes cfg_wdata into register cfg_addr
//   (0 = hex_default, 1 = middle_c_octave); write only while idle.
module note_name_parser_top #(
    parameter int MAX_DIGITS = 255
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_char_code,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [6:0]                       m_note_number,
    output logic                             m_note_valid,
    output logic                             m_from_name,
    input  logic                             cfg_wr_en,
    input  logic [nnp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [nnp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int NUM_CAP = 255;
    localparam int VW      = $clog2(NUM_CAP + 1);
    localparam int CW      = $clog2(MAX_DIGITS + 1);

    // Configuration registers
    logic              hex_default_reg;
    logic signed [4:0] middle_c_reg;

    // Input stage
    logic              in_vld_reg, in_vld_next;
    logic [7:0]        in_char_reg;

    // Numeric parse state
    nnp_pkg::num_ctl_t num_ctl_reg, num_ctl_next, num_ctl_acc;
    logic [VW-1:0]     num_value_reg, num_value_next, num_value_acc;
    logic [CW-1:0]     num_count_reg, num_count_next, num_count_acc;

    // Output stage
    logic              out_vld_reg, out_vld_next;
    logic [6:0]        out_note_reg, out_note_next;
    logic              out_nvalid_reg, out_nvalid_next;
    logic              out_from_name_reg, out_from_name_next;

    logic              is_term;
    logic              advance;
    logic              step;
    logic              finish;
    logic              num_good;
    nnp_pkg::name_res_t name_res;

    // Advance the input beat unless it is a terminator blocked by a full output with m_ready low
    assign is_term = (in_char_reg == nnp_pkg::CH_NUL);
    assign advance = in_vld_reg && (!is_term || !out_vld_reg || m_ready);
    assign step    = advance && !is_term;
    assign finish  = advance && is_term;
    assign s_ready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hex_default_reg <= 1'b0;
            middle_c_reg    <= nnp_pkg::MIDDLE_C_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                nnp_pkg::CFG_HEX_DEFAULT: hex_default_reg <= cfg_wdata[0];
                nnp_pkg::CFG_MIDDLE_C:    middle_c_reg    <= $signed(cfg_wdata);
                default: ;
            endcase
        end
    end

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_char_code;
        end
    end

    nnp_num_acc #(
        .MAX_DIGITS (MAX_DIGITS),
        .CAP        (NUM_CAP)
    ) u_num_acc (
        .char_i        (in_char_reg),
        .hex_default_i (hex_default_reg),
        .ctl_i         (num_ctl_reg),
        .value_i       (num_value_reg),
        .count_i       (num_count_reg),
        .ctl_o         (num_ctl_acc),
        .value_o       (num_value_acc),
        .count_o       (num_count_acc)
    );

    // Update the numeric parse on every character; drop it after a terminator
    always_comb begin
        num_ctl_next   = num_ctl_reg;
        num_value_next = num_value_reg;
        num_count_next = num_count_reg;
        if (finish) begin
            num_ctl_next   = '{pos: nnp_pkg::NUM_PREFIX, hex: 1'b0, ok: 1'b1};
            num_value_next = '0;
            num_count_next = '0;
        end else if (step) begin
            num_ctl_next   = num_ctl_acc;
            num_value_next = num_value_acc;
            num_count_next = num_count_acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_ctl_reg   <= '{pos: nnp_pkg::NUM_PREFIX, hex: 1'b0, ok: 1'b1};
            num_value_reg <= '0;
            num_count_reg <= '0;
        end else begin
            num_ctl_reg   <= num_ctl_next;
            num_value_reg <= num_value_next;
            num_count_reg <= num_count_next;
        end
    end

    nnp_name_path #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_name_path (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_i        (step),
        .clear_i       (finish),
        .char_i        (in_char_reg),
        .hex_default_i (hex_default_reg),
        .middle_c_i    (middle_c_reg),
        .res_o         (name_res)
    );

    // A bare "0" prefix at the terminator reads as the value 0, already held
    assign num_good = num_ctl_reg.ok && (num_value_reg <= VW'(127));

    always_comb begin
        out_note_next      = out_note_reg;
        out_nvalid_next    = out_nvalid_reg;
        out_from_name_next = out_from_name_reg;
        out_vld_next       = out_vld_reg && !m_ready;
        if (finish) begin
            out_vld_next = 1'b1;
            priority if (num_good) begin
                out_note_next      = num_value_reg[6:0];
                out_nvalid_next    = 1'b1;
                out_from_name_next = 1'b0;
            end else if (name_res.valid) begin
                out_note_next      = name_res.note;
                out_nvalid_next    = 1'b1;
                out_from_name_next = 1'b1;
            end else begin
                out_note_next      = '0;
                out_nvalid_next    = 1'b0;
                out_from_name_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_note_reg      <= out_note_next;
        out_nvalid_reg    <= out_nvalid_next;
        out_from_name_reg <= out_from_name_next;
    end

    assign m_valid       = out_vld_reg;
    assign m_note_number = out_note_reg;
    assign m_note_valid  = out_nvalid_reg;
    assign m_from_name   = out_from_name_reg;

endmodule

// File: design/nnp_checker.sv
// Port-level checks for the note name parser, bound to the top level.
// Depends on note_name_parser_top.
module nnp_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [6:0] m_note_number,
    input logic       m_note_valid,
    input logic       m_from_name
);

    // A stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_note_number)
                                && $stable(m_note_valid) && $stable(m_from_name))
        else $error("result beat changed while stalled");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_note_valid |-> (m_note_number == 7'd0) && !m_from_name)
        else $error("invalid result carries a note or a name flag");

    a_name_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_from_name |-> m_note_valid)
        else $error("name flag set on an invalid result");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result channel not empty after reset");

endmodule

bind note_name_parser_top nnp_checker u_nnp_checker (.*);
